// ===== hdl/kvca_pkg.sv =====
// ----------------------------------------------------------------------------
// kvca_pkg: shared definitions for the KV cache slot allocator
// Sizes, field widths, the cell word layout and the shared ALU operations.
// ----------------------------------------------------------------------------
package kvca_pkg;

  localparam int CELLS    = 256;
  localparam int MAX_SEQS = 8;

  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ALU_W   = CNT_W + 1;
  localparam int TST_W   = CNT_W + 1;

  localparam int CFG_W   = 9;
  localparam int RUN_W   = 9;
  localparam int SPOS_W  = 12;
  localparam int MASK_W  = 8;
  localparam int SLOT_W  = 8;
  localparam int CMAX_W  = 9;
  localparam int POS_W   = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);
  localparam logic             REQ_ALLOC = 1'b0;
  localparam logic             REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD = 2'b01,
    ALU_SUB = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [MAX_SEQS-1:0] seq;
  } cell_word_t;

  localparam int CELL_WORD_W = $bits(cell_word_t);

endpackage

// ===== hdl/kv_cache_contiguous_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// kv_cache_contiguous_slot_allocator: contiguous run allocator for KV cells
// Sequence from request transfer to result valid: a clear goes straight to the result. An
//   allocate runs the range checks, probes cells one at a time (with extra steps per used
//   cell and per wrap), closes a found run, writes it, scans down for the cell max and
//   loads the result.
// Throughput: one item at a time, set by the single search/write/scan sequencer.
// Reset: synchronous; all cells read as free at once, head 0, cache_size 256.
// ----------------------------------------------------------------------------
module kv_cache_contiguous_slot_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: cache_size
  input  logic                          cfg_we,
  input  logic [kvca_pkg::CFG_W-1:0]    cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [kvca_pkg::RUN_W-1:0]    run_length,
  input  logic [kvca_pkg::SPOS_W-1:0]   start_pos,
  input  logic [kvca_pkg::MASK_W-1:0]   seq_mask,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [kvca_pkg::SLOT_W-1:0]   slot_start,
  output logic [kvca_pkg::CMAX_W-1:0]   cell_max
);

  // The sequencer walks through the phases of one request. The shared ALU
  // does every range check (run against cache, head against the wrap limit,
  // tested count against cache size) and the wrap accounting; simple
  // counters step the probe pointer, the run counter and the scan pointer.
  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_LIMIT    = 11'b000_0000_0010,
    S_CHECK    = 11'b000_0000_0100,
    S_WRAP     = 11'b000_0000_1000,
    S_ACCUM    = 11'b000_0001_0000,
    S_PROBE    = 11'b000_0010_0000,
    S_FAILCHK  = 11'b000_0100_0000,
    S_WRITE    = 11'b000_1000_0000,
    S_SCANINIT = 11'b001_0000_0000,
    S_SCAN     = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [kvca_pkg::CFG_W-1:0]    cache_size;
  logic [kvca_pkg::CNT_W-1:0]    n_cells;

  // Cell used flags. A cell is used exactly when it has been written since
  // the last clear, so these flags also stand in for the cleared RAM contents.
  logic [kvca_pkg::CELLS-1:0]    cell_valid;

  // Request and search state
  logic [kvca_pkg::RUN_W-1:0]    len;
  logic [kvca_pkg::MAX_SEQS-1:0] mask;
  logic [kvca_pkg::POS_W-1:0]    pos_cnt;
  logic [kvca_pkg::CNT_W-1:0]    head;
  logic [kvca_pkg::CNT_W-1:0]    limit;
  logic [kvca_pkg::CNT_W-1:0]    probe;
  logic [kvca_pkg::RUN_W-1:0]    run_cnt;
  logic [kvca_pkg::TST_W-1:0]    tested;
  logic [kvca_pkg::CNT_W-1:0]    wrap_gap;
  logic                          res_ok;
  logic [kvca_pkg::CNT_W-1:0]    cmax;

  // Write-back pipeline: the read of one cell overlaps the write of the last.
  logic                          wr_pend;
  logic [kvca_pkg::CELL_AW-1:0]  wr_addr;
  logic [kvca_pkg::POS_W-1:0]    wr_pos;
  logic                          wr_old;

  // Cell-max scan pipeline, walking down from the top active cell.
  logic [kvca_pkg::CELL_AW-1:0]  scan_addr;
  logic                          scan_more;
  logic                          chk_pend;
  logic [kvca_pkg::CELL_AW-1:0]  chk_addr;
  logic                          chk_valid;
  logic                          scan_hit;

  logic                          probe_used;
  logic                          scan_used;

  kvca_pkg::alu_op_t             alu_op;
  logic [kvca_pkg::ALU_W-1:0]    alu_a;
  logic [kvca_pkg::ALU_W-1:0]    alu_b;
  logic [kvca_pkg::ALU_W-1:0]    alu_res;
  logic                          alu_carry;

  logic                          ram_we;
  logic [kvca_pkg::CELL_AW-1:0]  ram_raddr;
  kvca_pkg::cell_word_t          ram_wdata;
  kvca_pkg::cell_word_t          ram_rdata;

  // Register values above the built depth act as the built depth.
  assign n_cells = (int'(cache_size) > kvca_pkg::CELLS) ? kvca_pkg::CNT_W'(kvca_pkg::CELLS)
                                                        : kvca_pkg::CNT_W'(cache_size);

  assign in_ready   = (state == S_IDLE);
  assign probe_used = cell_valid[probe[kvca_pkg::CELL_AW-1:0]];
  assign scan_used  = cell_valid[scan_addr];
  assign scan_hit   = chk_pend && chk_valid && (ram_rdata.seq != '0);

  // Operand selection for the shared ALU, one use per sequencer state.
  always_comb begin
    alu_op = kvca_pkg::ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_LIMIT: begin
        alu_a = kvca_pkg::ALU_W'(n_cells);
        alu_b = kvca_pkg::ALU_W'(len);
      end
      S_CHECK: begin
        alu_a = kvca_pkg::ALU_W'(limit);
        alu_b = kvca_pkg::ALU_W'(head);
      end
      S_WRAP: begin
        alu_a = kvca_pkg::ALU_W'(n_cells);
        alu_b = kvca_pkg::ALU_W'(head);
      end
      S_ACCUM: begin
        alu_op = kvca_pkg::ALU_ADD;
        alu_a  = kvca_pkg::ALU_W'(tested);
        alu_b  = kvca_pkg::ALU_W'(wrap_gap);
      end
      S_FAILCHK: begin
        alu_a = kvca_pkg::ALU_W'(tested);
        alu_b = kvca_pkg::ALU_W'(n_cells);
      end
      S_SCANINIT: begin
        alu_a = kvca_pkg::ALU_W'(n_cells);
        alu_b = kvca_pkg::ALU_W'(1);
      end
      default: begin
        alu_op = kvca_pkg::ALU_SUB;
      end
    endcase
  end

  kvca_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // Cell store: position and sequence mask per cell. Entries whose used flag
  // is clear are never trusted, so the store needs no clearing.
  assign ram_we          = wr_pend;
  assign ram_wdata.pos   = wr_pos;
  assign ram_wdata.seq   = (wr_old ? ram_rdata.seq : '0) | mask;
  assign ram_raddr       = (state == S_SCAN) ? scan_addr : probe[kvca_pkg::CELL_AW-1:0];

  kvca_ram #(
    .WIDTH (kvca_pkg::CELL_WORD_W),
    .DEPTH (kvca_pkg::CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cache_size <= kvca_pkg::CFG_RESET;
      cell_valid <= '0;
      head       <= '0;
      out_valid  <= 1'b0;
      wr_pend    <= 1'b0;
      scan_more  <= 1'b0;
      chk_pend   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_size <= cfg_data;
      end
      // In the result state the load below decides the valid flag itself.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (wr_pend) begin
        cell_valid[wr_addr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            len     <= run_length;
            mask    <= seq_mask[kvca_pkg::MAX_SEQS-1:0];
            pos_cnt <= kvca_pkg::POS_W'(start_pos);
            if (req_type == kvca_pkg::REQ_CLEAR) begin
              // A clear frees every cell at once through the used flags.
              cell_valid <= '0;
              head       <= '0;
              res_ok     <= 1'b1;
              cmax       <= kvca_pkg::CNT_W'(1);
              state      <= S_DONE;
            end else begin
              state <= S_LIMIT;
            end
          end
        end

        S_LIMIT: begin
          // A run longer than the cache fails at once and leaves the head.
          tested <= '0;
          if (alu_carry) begin
            res_ok <= 1'b0;
            state  <= S_SCANINIT;
          end else begin
            limit <= alu_res[kvca_pkg::CNT_W-1:0];
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          // The run fits from the head only if head <= n - len.
          probe   <= head;
          run_cnt <= '0;
          state   <= alu_carry ? S_WRAP : S_PROBE;
        end

        S_WRAP: begin
          // The cells skipped at the top count as tested, unless the head
          // already lay beyond a shrunken cache.
          wrap_gap <= alu_carry ? '0 : alu_res[kvca_pkg::CNT_W-1:0];
          head     <= '0;
          state    <= S_ACCUM;
        end

        S_ACCUM: begin
          tested <= alu_res[kvca_pkg::TST_W-1:0];
          state  <= S_CHECK;
        end

        S_PROBE: begin
          if (run_cnt == len) begin
            res_ok  <= 1'b1;
            probe   <= head;
            run_cnt <= '0;
            state   <= S_WRITE;
          end else if (probe_used) begin
            head   <= probe + 1'b1;
            tested <= tested + 1'b1;
            state  <= S_FAILCHK;
          end else begin
            probe   <= probe + 1'b1;
            run_cnt <= run_cnt + 1'b1;
            tested  <= tested + 1'b1;
          end
        end

        S_FAILCHK: begin
          // Give up once a whole cache of cells has been tested.
          if (!alu_carry) begin
            res_ok <= 1'b0;
            state  <= S_SCANINIT;
          end else begin
            state <= S_CHECK;
          end
        end

        S_WRITE: begin
          if (run_cnt != len) begin
            wr_pend <= 1'b1;
            wr_addr <= probe[kvca_pkg::CELL_AW-1:0];
            wr_pos  <= pos_cnt;
            wr_old  <= probe_used;
            probe   <= probe + 1'b1;
            run_cnt <= run_cnt + 1'b1;
            pos_cnt <= pos_cnt + 1'b1;
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              state <= S_SCANINIT;
            end
          end
        end

        S_SCANINIT: begin
          // Cell 0 never counts, so with one active cell or none the answer
          // is 1 without a scan.
          cmax <= kvca_pkg::CNT_W'(1);
          if (alu_carry || (alu_res == '0)) begin
            state <= S_DONE;
          end else begin
            scan_addr <= alu_res[kvca_pkg::CELL_AW-1:0];
            scan_more <= 1'b1;
            chk_pend  <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            cmax      <= kvca_pkg::CNT_W'(chk_addr) + 1'b1;
            scan_more <= 1'b0;
            chk_pend  <= 1'b0;
            state     <= S_DONE;
          end else begin
            if (scan_more) begin
              chk_pend  <= 1'b1;
              chk_addr  <= scan_addr;
              chk_valid <= scan_used;
              scan_addr <= scan_addr - 1'b1;
              scan_more <= (scan_addr != kvca_pkg::CELL_AW'(1));
            end else begin
              chk_pend <= 1'b0;
              if (!chk_pend) begin
                state <= S_DONE;
              end
            end
          end
        end

        S_DONE: begin
          // The result register frees the sequencer as soon as it is loaded.
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            ok         <= res_ok;
            slot_start <= kvca_pkg::SLOT_W'(head);
            cell_max   <= kvca_pkg::CMAX_W'(cmax);
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/kvca_ram.sv =====
// ----------------------------------------------------------------------------
// kvca_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kvca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kvca_alu.sv =====
// ----------------------------------------------------------------------------
// kvca_alu: shared add/subtract unit
// Adds or subtracts two operands; carry is the carry out on an add and the
// borrow (a below b) on a subtract.
// ----------------------------------------------------------------------------
module kvca_alu (
  input  kvca_pkg::alu_op_t         op,
  input  logic [kvca_pkg::ALU_W-1:0] a,
  input  logic [kvca_pkg::ALU_W-1:0] b,
  output logic [kvca_pkg::ALU_W-1:0] res,
  output logic                       carry
);

  always_comb begin
    case (op)
      kvca_pkg::ALU_ADD: {carry, res} = {1'b0, a} + {1'b0, b};
      kvca_pkg::ALU_SUB: {carry, res} = {1'b0, a} - {1'b0, b};
      default:           {carry, res} = '0;
    endcase
  end

endmodule

// ===== hdl/kvca_checker.sv =====
// ----------------------------------------------------------------------------
// kvca_checker: port-level checks for the KV cache slot allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module kvca_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        ok,
  input logic [kvca_pkg::SLOT_W-1:0] slot_start,
  input logic [kvca_pkg::CMAX_W-1:0] cell_max
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(slot_start)
                                && $stable(cell_max))
    else $error("result changed while stalled");

  // The cell-max count is always between one and the built depth.
  a_cmax_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_max != '0) && (int'(cell_max) <= kvca_pkg::CELLS))
    else $error("cell_max out of range");

  // One request at a time: the block is busy right after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A fresh result is only raised while the block is working on a request.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request");

endmodule

bind kv_cache_contiguous_slot_allocator kvca_checker u_kvca_checker (.*);

// ===== tb/kv_cache_contiguous_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// kv_cache_contiguous_slot_allocator_tb: self-checking bench for the allocator
// Sends allocate and clear requests through the request channel and keeps a
// cycle-free copy of the cell table, the search head and the cache size. That
// copy predicts every result, and the result channel is checked field by field.
// A directed opening is followed by random phases at several cache sizes.
// ----------------------------------------------------------------------------
module kv_cache_contiguous_slot_allocator_tb;

  // Longest run of cycles without any transfer before the run is abandoned.
  // This leaves a wide margin over the slowest allocate.
  localparam int   STALL_LIMIT = 20000;

  typedef struct packed {
    logic                        req_type;
    logic [kvca_pkg::RUN_W-1:0]  run_length;
    logic [kvca_pkg::SPOS_W-1:0] start_pos;
    logic [kvca_pkg::MASK_W-1:0] seq_mask;
  } slot_req_t;

  typedef struct packed {
    logic                        ok;
    logic [kvca_pkg::SLOT_W-1:0] slot_start;
    logic [kvca_pkg::CMAX_W-1:0] cell_max;
  } slot_result_t;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        cfg_we     = 1'b0;
  logic [kvca_pkg::CFG_W-1:0]  cfg_data   = '0;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic                        req_type   = 1'b0;
  logic [kvca_pkg::RUN_W-1:0]  run_length = '0;
  logic [kvca_pkg::SPOS_W-1:0] start_pos  = '0;
  logic [kvca_pkg::MASK_W-1:0] seq_mask   = '0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic                        ok;
  logic [kvca_pkg::SLOT_W-1:0] slot_start;
  logic [kvca_pkg::CMAX_W-1:0] cell_max;

  kv_cache_contiguous_slot_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .run_length (run_length),
    .start_pos  (start_pos),
    .seq_mask   (seq_mask),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .slot_start (slot_start),
    .cell_max   (cell_max)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the allocator state. Cell positions are never visible at the
  // outputs, so only the used flags and the sequence masks are tracked.
  // --------------------------------------------------------------------------
  bit                            occupied  [kvca_pkg::CELLS];
  logic [kvca_pkg::MAX_SEQS-1:0] cell_seqs [kvca_pkg::CELLS];
  int                            head;
  int                            cache_cells;

  slot_req_t    pending_reqs [$];
  slot_result_t results_due  [$];
  slot_req_t    current_req;
  slot_result_t due_result;
  slot_result_t front_result;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  int mismatches = 0;
  int n_taken    = 0;
  int n_clears   = 0;
  int n_refused  = 0;
  int n_checked  = 0;
  int n_sizes    = 0;
  int quiet_cycles = 0;

  // Cache sizes visited by the random phases and the requests sent in each.
  // They include the zero size, a single cell, and values above the built depth.
  int plan_size  [10] = '{16, 40, 1, 0, 511, 100, 2, 300, 64, 8};
  int plan_items [10] = '{50, 50, 20, 15, 40, 60, 20, 40, 70, 55};

  function automatic void clear_cells();
    for (int c = 0; c < kvca_pkg::CELLS; c++) begin
      occupied[c]  = 1'b0;
      cell_seqs[c] = '0;
    end
    head = 0;
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic slot_result_t apply_request(slot_req_t r);
    slot_result_t res;
    int  n;
    int  len;
    int  tested;
    int  top;
    bit  found;
    bit  done;
    bit  hit;
    n   = (cache_cells > kvca_pkg::CELLS) ? kvca_pkg::CELLS : cache_cells;
    res = '0;
    if (r.req_type == kvca_pkg::REQ_CLEAR) begin
      clear_cells();
      res.ok = 1'b1;
    end else begin
      len    = int'(r.run_length);
      found  = 1'b0;
      if (len <= n) begin
        tested = 0;
        done   = 1'b0;
        while (!done) begin
          if (head + len > n) begin
            // A head left beyond a shrunken cache wraps without counting cells.
            if (head <= n)
              tested += n - head;
            head = 0;
          end else begin
            hit = 1'b0;
            for (int i = 0; i < len && !hit; i++) begin
              if (occupied[head + i]) begin
                hit     = 1'b1;
                tested += i + 1;
                head   += i + 1;
              end
            end
            if (!hit) begin
              found = 1'b1;
              done  = 1'b1;
            end else if (tested >= n) begin
              done = 1'b1;
            end
          end
        end
        if (found) begin
          for (int i = 0; i < len; i++) begin
            occupied[head + i]  = 1'b1;
            cell_seqs[head + i] = cell_seqs[head + i] | r.seq_mask;
          end
        end
      end
      res.ok = found;
    end
    res.slot_start = head[kvca_pkg::SLOT_W-1:0];
    // Cell 0 never counts; cells with an empty sequence mask do not either.
    top = 1;
    for (int c = n - 1; c >= 1 && top == 1; c--) begin
      if (occupied[c] && cell_seqs[c] != '0)
        top = c + 1;
    end
    res.cell_max = top[kvca_pkg::CMAX_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH result %0d, %s: got %0d, expected %0d", n_checked, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A new item is only put up once the previous transfer has
  // happened, so valid and the payload hold steady while the block stalls. The
  // expected result is worked out at the edge where the transfer takes place.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_result = apply_request(current_req);
        results_due.insert(results_due.size(), due_result);
        n_taken++;
        if (current_req.req_type == kvca_pkg::REQ_CLEAR)
          n_clears++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
          current_req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          req_type   <= current_req.req_type;
          run_length <= current_req.run_length;
          start_pos  <= current_req.start_pos;
          seq_mask   <= current_req.seq_mask;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each result transfer is matched against the oldest
  // outstanding prediction; the receiver stalls at random unless steady.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (results_due.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          front_result = results_due.pop_front();
          if (ok !== front_result.ok)
            report_mismatch("ok", int'(ok), int'(front_result.ok));
          if (slot_start !== front_result.slot_start)
            report_mismatch("slot_start", int'(slot_start), int'(front_result.slot_start));
          if (cell_max !== front_result.cell_max)
            report_mismatch("cell_max", int'(cell_max), int'(front_result.cell_max));
          if (front_result.ok == 1'b0)
            n_refused++;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  // Watchdog: gives up when no transfer of either kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, results_due.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_alloc(int len, int pos, int mask);
    slot_req_t r;
    r.req_type   = kvca_pkg::REQ_ALLOC;
    r.run_length = kvca_pkg::RUN_W'(len);
    r.start_pos  = kvca_pkg::SPOS_W'(pos);
    r.seq_mask   = kvca_pkg::MASK_W'(mask);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_clear();
    slot_req_t r;
    r.req_type   = kvca_pkg::REQ_CLEAR;
    r.run_length = kvca_pkg::RUN_W'($urandom_range(511));
    r.start_pos  = kvca_pkg::SPOS_W'($urandom_range(4095));
    r.seq_mask   = kvca_pkg::MASK_W'($urandom_range(255));
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Waits until every queued request has been transferred and answered.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // The cache size may only change while the block has nothing in hand.
  task automatic set_cache_size(int value);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_data   <= kvca_pkg::CFG_W'(value);
    cfg_we     <= 1'b1;
    cache_cells = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_sizes++;
  endtask

  // Mostly short runs that fit, some up to the whole cache, a few empty runs
  // and a few that are longer than the cache.
  function automatic int pick_length(int n);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)
      return int'($urandom_range(511, n + 1));
    if (roll < 8 || n == 0)
      return 0;
    if (roll < 75)
      return int'($urandom_range((n < 8) ? n : 8, 1));
    return int'($urandom_range(n, 1));
  endfunction

  function automatic int pick_mask();
    return ($urandom_range(99) < 15) ? 0 : int'($urandom_range(255));
  endfunction

  initial begin
    int active;
    cache_cells = int'(kvca_pkg::CFG_RESET);
    clear_cells();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset cache size of 256 cells.
    push_alloc(0, 0, 0);            // empty run succeeds at the head
    push_alloc(1, 4095, 255);       // cell 0 is used but never counts to cell_max
    push_alloc(3, 2048, 1);         // head hops past cell 0
    push_alloc(2, 2047, 0);         // empty sequence mask: used but not counted
    push_alloc(256, 100, 3);        // whole cache wanted while partly used
    push_alloc(257, 5, 7);          // run longer than the cache
    push_alloc(511, 4095, 170);
    push_clear();
    push_alloc(256, 291, 128);      // whole cache after a clear
    push_alloc(1, 0, 1);            // full cache: head ends one past the end
    push_alloc(0, 1, 2);            // empty run with the head at the end
    push_clear();
    push_alloc(200, 1365, 85);
    push_alloc(10, 2730, 15);       // walks the head up to cell 200
    push_alloc(56, 3000, 240);      // fails after wrapping round
    push_alloc(5, 1234, 0);

    // Random phases. The first one shrinks the cache below a head left high
    // by the directed part, so the search wraps without counting cells.
    for (int p = 0; p < 10; p++) begin
      set_cache_size(plan_size[p]);
      steady = (p == 8);
      active = (plan_size[p] > kvca_pkg::CELLS) ? kvca_pkg::CELLS : plan_size[p];
      repeat (plan_items[p]) begin
        if ($urandom_range(99) < 8)
          push_clear();
        else
          push_alloc(pick_length(active), int'($urandom_range(4095)), pick_mask());
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d requests transferred (%0d clears) across %0d cache sizes",
             n_taken, n_clears, n_sizes);
    $display("%0d results checked, %0d refused, %0d mismatches",
             n_checked, n_refused, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
